@@ hdl/lru_keyed_cache_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// lru keyed cache table assertion macros
// concurrent check wrappers used by the asserting top file
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_TABLE_TOP_MACROS_SVH
`define LRU_KEYED_CACHE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define LKCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkct check failed");

// next-cycle implication
`define LKCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkct check failed");

`endif

@@ hdl/lkct_pkg.sv @@
// ----------------------------------------------------------------------------
// lkct_pkg
// sizes, opcodes and controller/datapath command and status types
// ----------------------------------------------------------------------------
package lkct_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int OP_W    = 2;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [OP_W-1:0] OP_GET = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;
  localparam logic [OP_W-1:0] OP_POP = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic TGT_MATCH  = 1'b0;
  localparam logic TGT_OLDEST = 1'b1;

  typedef struct packed {
    logic             load;
    logic             scan_rd;
    logic [IDX_W-1:0] scan_addr;
    logic             tgt_load;
    logic             tgt_sel;
    logic             tgt_rd;
    logic             res_cap;
    logic             touch;
    logic             remove;
    logic             insert;
    logic             out_load;
  } lkct_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             touch;
    logic             match_hit;
    logic             old_hit;
    logic             full;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } lkct_stat_t;

endpackage

@@ hdl/lkct_if.sv @@
// ----------------------------------------------------------------------------
// lkct channel interfaces
// request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lkct_in_if;
  import lkct_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic             touch;

  modport source (output valid, op, key, value, touch, input ready);
  modport sink   (input valid, op, key, value, touch, output ready);
endinterface

interface lkct_out_if;
  import lkct_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [KEY_W-1:0] result_key;
  logic [VAL_W-1:0] result_value;

  modport source (output valid, found, result_key, result_value, input ready);
  modport sink   (input valid, found, result_key, result_value, output ready);
endinterface

@@ hdl/lkct_datapath.sv @@
// ----------------------------------------------------------------------------
// lkct_datapath
// key/value memories, valid bits, recency ranks, scan logic and result register
// ----------------------------------------------------------------------------
module lkct_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lkct_pkg::lkct_cmd_t       cmd,
  output lkct_pkg::lkct_stat_t      stat,
  input  logic [lkct_pkg::OP_W-1:0]  in_op,
  input  logic [lkct_pkg::KEY_W-1:0] in_key,
  input  logic [lkct_pkg::VAL_W-1:0] in_value,
  input  logic                      in_touch,
  input  logic                      cfg_we,
  input  logic [lkct_pkg::CAP_W-1:0] cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [lkct_pkg::KEY_W-1:0] out_result_key,
  output logic [lkct_pkg::VAL_W-1:0] out_result_value
);
  import lkct_pkg::*;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [IDX_W-1:0] rd_addr;

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             touch_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]   rank_r   [ENTRIES];
  logic [IDX_W-1:0]   rank_nxt [ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic             pv_r;
  logic [IDX_W-1:0] pidx_r;
  logic             match_hit_r, old_hit_r, free_hit_r, rem_r;
  logic [IDX_W-1:0] match_idx_r, old_idx_r, free_idx_r, tgt_r;
  logic             hit_now, old_now, free_now;

  logic             ins_ok;
  logic [IDX_W-1:0] ins_idx;
  logic [IDX_W-1:0] tgt_rank;

  logic             res_found_r;
  logic [KEY_W-1:0] res_key_r;
  logic [VAL_W-1:0] res_val_r;
  logic             out_valid_r, out_found_r;
  logic [KEY_W-1:0] out_key_r;
  logic [VAL_W-1:0] out_val_r;

  // memories
  assign rd_addr = cmd.tgt_rd ? tgt_r : cmd.scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.insert && ins_ok) begin
      key_mem[ins_idx] <= key_r;
      val_mem[ins_idx] <= value_r;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  // effective capacity
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // scan compare on registered read data
  assign hit_now  = pv_r && valid_r[pidx_r] && (rd_key_r == key_r);
  assign old_now  = pv_r && valid_r[pidx_r] &&
                    (CNT_W'(rank_r[pidx_r]) == (count_r - CNT_W'(1)));
  assign free_now = pv_r && !valid_r[pidx_r];

  // lowest free slot, including one just vacated
  always_comb begin
    if (rem_r && (!free_hit_r || (tgt_r < free_idx_r))) begin
      ins_ok  = 1'b1;
      ins_idx = tgt_r;
    end else begin
      ins_ok  = free_hit_r;
      ins_idx = free_idx_r;
    end
  end

  assign tgt_rank = rank_r[tgt_r];

  // rank and valid update
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (cmd.touch) begin
        if (IDX_W'(i) == tgt_r) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < tgt_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      if (cmd.remove) begin
        if (IDX_W'(i) == tgt_r) begin
          valid_nxt[i] = 1'b0;
          rank_nxt[i]  = '0;
        end else if (valid_r[i] && (rank_r[i] > tgt_rank)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      if (cmd.insert && ins_ok) begin
        if (IDX_W'(i) == ins_idx) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    if (cmd.remove && (count_r != '0)) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.insert && ins_ok) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      count_r     <= '0;
      pv_r        <= 1'b0;
      match_hit_r <= 1'b0;
      old_hit_r   <= 1'b0;
      free_hit_r  <= 1'b0;
      rem_r       <= 1'b0;
      res_found_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      pv_r <= cmd.scan_rd;
      if (cmd.load) begin
        match_hit_r <= 1'b0;
        old_hit_r   <= 1'b0;
        free_hit_r  <= 1'b0;
        rem_r       <= 1'b0;
        res_found_r <= 1'b0;
      end else begin
        if (hit_now && !match_hit_r) begin
          match_hit_r <= 1'b1;
        end
        if (old_now) begin
          old_hit_r <= 1'b1;
        end
        if (free_now && !free_hit_r) begin
          free_hit_r <= 1'b1;
        end
        if (cmd.remove) begin
          rem_r <= 1'b1;
        end
        if (cmd.res_cap) begin
          res_found_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        out_found_r <= res_found_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pidx_r <= cmd.scan_addr;
    if (cmd.load) begin
      op_r      <= in_op;
      key_r     <= in_key;
      value_r   <= in_value;
      touch_r   <= in_touch;
      res_key_r <= '0;
      res_val_r <= '0;
    end else if (cmd.res_cap) begin
      res_key_r <= rd_key_r;
      res_val_r <= rd_val_r;
    end
    if (hit_now && !match_hit_r) begin
      match_idx_r <= pidx_r;
    end
    if (old_now) begin
      old_idx_r <= pidx_r;
    end
    if (free_now && !free_hit_r) begin
      free_idx_r <= pidx_r;
    end
    if (cmd.tgt_load) begin
      tgt_r <= (cmd.tgt_sel == TGT_OLDEST) ? old_idx_r : match_idx_r;
    end
    if (cmd.out_load) begin
      out_key_r <= res_key_r;
      out_val_r <= res_val_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.touch     = touch_r;
  assign stat.match_hit = match_hit_r;
  assign stat.old_hit   = old_hit_r;
  assign stat.full      = (count_r >= cap_eff);
  assign stat.out_busy  = out_valid_r && !out_ready;
  assign stat.count     = count_r;

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_key   = out_key_r;
  assign out_result_value = out_val_r;

endmodule

@@ hdl/lkct_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkct_ctrl
// operation sequencer: slot scan, target select, read, update, insert, result
// ----------------------------------------------------------------------------
module lkct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lkct_pkg::lkct_stat_t stat,
  output lkct_pkg::lkct_cmd_t  cmd
);
  import lkct_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_FLUSH  = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_INSERT = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.scan_addr = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        case (stat.op)
          OP_GET, OP_DEL: begin
            if (stat.match_hit) begin
              cmd.tgt_load = 1'b1;
              cmd.tgt_sel  = TGT_MATCH;
              state_nxt    = ST_READ;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_POP: begin
            if (stat.old_hit) begin
              cmd.tgt_load = 1'b1;
              cmd.tgt_sel  = TGT_OLDEST;
              state_nxt    = ST_READ;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            if (stat.match_hit) begin
              cmd.tgt_load = 1'b1;
              cmd.tgt_sel  = TGT_MATCH;
              state_nxt    = ST_READ;
            end else if (stat.full && stat.old_hit) begin
              cmd.tgt_load = 1'b1;
              cmd.tgt_sel  = TGT_OLDEST;
              state_nxt    = ST_READ;
            end else begin
              state_nxt = ST_INSERT;
            end
          end
        endcase
      end
      ST_READ: begin
        cmd.tgt_rd = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.res_cap = 1'b1;
        if (stat.op == OP_GET) begin
          cmd.touch = stat.touch;
        end else begin
          cmd.remove = 1'b1;
        end
        state_nxt = (stat.op == OP_PUT) ? ST_INSERT : ST_DONE;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/lru_keyed_cache_table_top.sv @@
// ----------------------------------------------------------------------------
// lru_keyed_cache_table_top
// Keyed table of up to 16 entries kept in recency order, with get, put,
// delete and pop-least-recent requests and one result per request. The key
// memory is scanned one slot per cycle over all 16 slots (finding the matching
// key, the least recent entry and the lowest free slot), then the chosen slot
// is read and the ranks, valid bits and memories are updated. A get or delete
// miss and a pop of an empty table skip the read and update; a put of a new
// key with room skips them and inserts; a get, delete or pop that finds an
// entry reads and updates; a put that replaces or evicts reads, updates and
// then inserts. The next request is taken from the cycle the result becomes
// valid; no request is taken before the previous one is done, and the result
// waits while the result channel stalls. A new request is taken while the
// previous result still waits on the result channel. The user must write
// capacity_in_use through cfg_we/cfg_wdata while idle, unchecked by the block.
// ----------------------------------------------------------------------------
`include "lru_keyed_cache_table_top_macros.svh"

module lru_keyed_cache_table_top (
  input  logic                       clk,
  input  logic                       rst_n,
  lkct_in_if.sink                    in_ch,
  lkct_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [lkct_pkg::CAP_W-1:0] cfg_wdata
);
  import lkct_pkg::*;

  lkct_cmd_t  cmd;
  lkct_stat_t stat;

  lkct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkct_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_ch.op),
    .in_key           (in_ch.key),
    .in_value         (in_ch.value),
    .in_touch         (in_ch.touch),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_found        (out_ch.found),
    .out_result_key   (out_ch.result_key),
    .out_result_value (out_ch.result_value)
  );

  `LKCT_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LKCT_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.found, out_ch.result_key == '0 && out_ch.result_value == '0)
  `LKCT_ASSERT_IMPL(a_insert_room, clk, rst_n, cmd.insert, stat.count < CNT_W'(ENTRIES))

endmodule
